>>> design/ihsr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihsr_pkg
// Shared types, sequence program and constants for the humidity sensor reader.
// ----------------------------------------------------------------------------
package ihsr_pkg;

    typedef enum logic [3:0] {
        OP_IDLE, OP_PWAIT, OP_CWAIT, OP_START, OP_SEND, OP_ACK, OP_ACKR,
        OP_RSTOP, OP_MACK, OP_RECV, OP_STOP, OP_FSTOP, OP_FINISH
    } op_t;

    localparam int STEP_W = 6;
    localparam logic [STEP_W-1:0] STEP_PWAIT  = 6'd1;
    localparam logic [STEP_W-1:0] STEP_FINISH = 6'd45;
    localparam logic [STEP_W-1:0] STEP_FSTOP  = 6'd46;

    // configuration register indexes
    localparam logic [2:0] CFG_DEV_ADDR  = 3'd0;
    localparam logic [2:0] CFG_MODE      = 3'd1;
    localparam logic [2:0] CFG_RETRY     = 3'd2;
    localparam logic [2:0] CFG_PWR_TICKS = 3'd3;
    localparam logic [2:0] CFG_CONV_TICKS = 3'd4;

    // error codes
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_ADDR     = 3'd1;
    localparam logic [2:0] ERR_CONFIG   = 3'd2;

    // stop arguments
    localparam logic [2:0] STOP_CFG  = 3'd2;
    localparam logic [2:0] STOP_TRIG_T = 3'd3;
    localparam logic [2:0] STOP_TRIG_H = 3'd4;
    localparam logic [2:0] STOP_KEEP_T = 3'd5;

    // send arguments
    localparam logic [2:0] SEND_ADDR_W = 3'd0;
    localparam logic [2:0] SEND_ADDR_R = 3'd1;
    localparam logic [2:0] SEND_PTR_CFG = 3'd2;
    localparam logic [2:0] SEND_MODE   = 3'd3;
    localparam logic [2:0] SEND_PTR_H  = 3'd5;

    localparam logic [2:0] ACK_IGNORE = 3'd3;

    typedef struct packed {
        logic [6:0]  dev_addr;
        logic [7:0]  mode;
        logic [3:0]  retry_limit;
        logic [19:0] pwr_ticks;
        logic [19:0] conv_ticks;
    } cfg_t;

    typedef struct packed {
        logic              scl_pull_low;
        logic              sda_pull_low;
        logic              sensor_power_on;
        logic              busy_res;
        logic              done_res;
        logic signed [11:0] temp_tenths;
        logic [6:0]        humidity_percent;
        logic [2:0]        sticky_error;
    } res_t;

    function automatic op_t prog_op(input logic [STEP_W-1:0] step);
        op_t o;
        case (step)
            6'd0:  o = OP_IDLE;
            6'd1:  o = OP_PWAIT;
            6'd2, 6'd13, 6'd20, 6'd29, 6'd36: o = OP_START;
            6'd3, 6'd6, 6'd8, 6'd10, 6'd14, 6'd16, 6'd21, 6'd30, 6'd32, 6'd37: o = OP_SEND;
            6'd4, 6'd22, 6'd38: o = OP_ACKR;
            6'd5, 6'd23, 6'd39: o = OP_RSTOP;
            6'd7, 6'd9, 6'd11, 6'd15, 6'd17, 6'd27, 6'd31, 6'd33, 6'd43: o = OP_ACK;
            6'd12, 6'd18, 6'd28, 6'd34, 6'd44: o = OP_STOP;
            6'd19, 6'd35: o = OP_CWAIT;
            6'd24, 6'd26, 6'd40, 6'd42: o = OP_RECV;
            6'd25, 6'd41: o = OP_MACK;
            6'd45: o = OP_FINISH;
            6'd46: o = OP_FSTOP;
            default: o = OP_IDLE;
        endcase
        return o;
    endfunction

    function automatic logic [2:0] prog_arg(input logic [STEP_W-1:0] step);
        logic [2:0] a;
        case (step)
            6'd6, 6'd11, 6'd12: a = 3'd2;
            6'd8, 6'd18:        a = 3'd3;
            6'd9, 6'd17, 6'd21, 6'd26, 6'd33, 6'd37, 6'd42: a = 3'd1;
            6'd10, 6'd16, 6'd34: a = 3'd4;
            6'd27, 6'd43:        a = 3'd3;
            6'd28, 6'd32:        a = 3'd5;
            default:             a = 3'd0;
        endcase
        return a;
    endfunction

    // floor(x / 65535) for x below 65535 * 2048
    function automatic logic [10:0] div65535(input logic [26:0] x);
        logic [10:0] hi;
        logic [16:0] sum;
        hi  = x[26:16];
        sum = {6'd0, hi} + {1'b0, x[15:0]};
        return hi + {10'd0, (sum >= 17'd65535)};
    endfunction

endpackage

>>> design/i2c_humidity_sensor_reader_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_humidity_sensor_reader_unit
// Bit-banged bus master reading temperature and humidity, one tick per word.
// ----------------------------------------------------------------------------
// each result word is registered in the cycle after its input word is accepted
// throughput: one word per cycle while the output is not stalled; the sequencer advances one tick per word
// the output register stalls input only while a result waits and m_tready is low
// reset (aresetn low, synchronous): sequencer idle, counters and results zero,
// configuration back to address 64, mode 0, retry 3, waits 60000 and 28000
module i2c_humidity_sensor_reader_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [0] start_request, [1] sda_level
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [0] scl_pull_low, [1] sda_pull_low,
                                    // [2] sensor_power_on, [3] busy_res, [4] done_res,
                                    // [16:5] temp_tenths, [23:17] humidity_percent,
                                    // [26:24] sticky_error
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [19:0] cfg_data
);
    import ihsr_pkg::*;

    cfg_t cfg_reg;
    res_t res_c, res_reg;
    logic m_valid_reg;
    logic in_acc;

    assign cfg_ready = 1'b1;
    assign s_tready  = !m_valid_reg || m_tready;
    assign in_acc    = s_tvalid && s_tready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dev_addr    <= 7'd64;
            cfg_reg.mode        <= 8'd0;
            cfg_reg.retry_limit <= 4'd3;
            cfg_reg.pwr_ticks   <= 20'd60000;
            cfg_reg.conv_ticks  <= 20'd28000;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_DEV_ADDR:   cfg_reg.dev_addr    <= cfg_data[6:0];
                CFG_MODE:       cfg_reg.mode        <= cfg_data[7:0];
                CFG_RETRY:      cfg_reg.retry_limit <= cfg_data[3:0];
                CFG_PWR_TICKS:  cfg_reg.pwr_ticks   <= cfg_data;
                CFG_CONV_TICKS: cfg_reg.conv_ticks  <= cfg_data;
                default:        ;
            endcase
        end
    end

    ihsr_seq u_seq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .tick_en       (in_acc),
        .start_request (s_tdata[0]),
        .sda_level     (s_tdata[1]),
        .cfg           (cfg_reg),
        .res           (res_c)
    );

    // output word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_acc) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            res_reg <= res_c;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, res_reg.sticky_error, res_reg.humidity_percent,
                       res_reg.temp_tenths, res_reg.done_res, res_reg.busy_res,
                       res_reg.sensor_power_on, res_reg.sda_pull_low, res_reg.scl_pull_low};

    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && res_reg.done_res) |-> (!res_reg.busy_res && !res_reg.sensor_power_on))
        else $error("done word shows busy or power");
    a_idle_released: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !res_reg.busy_res) |-> (!res_reg.scl_pull_low && !res_reg.sda_pull_low))
        else $error("lines driven while not busy");
    a_word_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc |=> m_valid_reg) else $error("accepted word produced no result");

endmodule

>>> design/ihsr_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihsr_seq
// Bus sequencer: one quarter-bit tick per enabled cycle, state and results.
// ----------------------------------------------------------------------------
module ihsr_seq (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           tick_en,
    input  logic           start_request,
    input  logic           sda_level,
    input  ihsr_pkg::cfg_t cfg,
    output ihsr_pkg::res_t res
);
    import ihsr_pkg::*;

    logic [STEP_W-1:0] step_reg, step_next;
    logic [1:0]  phase_reg, phase_next;
    logic [2:0]  bit_reg, bit_next;
    logic [7:0]  shift_reg, shift_next;
    logic [15:0] raw_reg, raw_next;
    logic [3:0]  retry_reg, retry_next;
    logic [19:0] wait_reg, wait_next;
    logic [2:0]  ack_reg, ack_next;
    logic [2:0]  cur_err_reg, cur_err_next;
    logic [2:0]  sticky_reg, sticky_next;
    logic [11:0] temp_reg, temp_next;
    logic [6:0]  hum_reg, hum_next;
    logic [11:0] pend_reg, pend_next;

    op_t        op;
    logic [2:0] arg;
    logic       ph_end, cell_low;
    logic       scl, sdl, power, busy, done;
    logic [7:0] tx_byte;
    logic [19:0] lim;
    logic [2:0]  mask;
    logic [10:0] temp_q, hum_q;

    assign op       = prog_op(step_reg);
    assign arg      = prog_arg(step_reg);
    assign ph_end   = (phase_reg == 2'd3);
    assign cell_low = (phase_reg == 2'd0) || (phase_reg == 2'd3);
    assign mask     = 3'd1 << arg[1:0];
    assign lim      = (op == OP_PWAIT) ? cfg.pwr_ticks : cfg.conv_ticks;

    // scaled conversions from the raw word
    assign temp_q = div65535(27'(raw_reg) * 27'd1650);
    assign hum_q  = div65535(27'(raw_reg) * 27'd100);

    // byte to transmit
    always_comb begin
        case (arg)
            SEND_ADDR_W:  tx_byte = {cfg.dev_addr, 1'b0};
            SEND_ADDR_R:  tx_byte = {cfg.dev_addr, 1'b1};
            SEND_PTR_CFG: tx_byte = 8'h02;
            SEND_MODE:    tx_byte = cfg.mode;
            SEND_PTR_H:   tx_byte = 8'h01;
            default:      tx_byte = 8'h00;
        endcase
    end

    // next state and line drive for one tick
    always_comb begin
        step_next = step_reg; phase_next = ph_end ? 2'd0 : phase_reg + 2'd1;
        bit_next = bit_reg; shift_next = shift_reg; raw_next = raw_reg;
        retry_next = retry_reg; wait_next = wait_reg; ack_next = ack_reg;
        cur_err_next = cur_err_reg; sticky_next = sticky_reg; temp_next = temp_reg;
        hum_next = hum_reg; pend_next = pend_reg;
        scl = 1'b0; sdl = 1'b0; power = 1'b1; busy = 1'b1; done = 1'b0;
        case (op)
            OP_PWAIT, OP_CWAIT: begin
                phase_next = 2'd0;
                if ({1'b0, wait_reg} + 21'd1 >= {1'b0, lim}) begin
                    wait_next = '0;
                    step_next = step_reg + 6'd1;
                end else begin
                    wait_next = wait_reg + 20'd1;
                end
            end
            OP_START: begin
                if (phase_reg == 2'd0) ack_next = '0;
                scl = (phase_reg == 2'd3);
                sdl = phase_reg[1];
                if (ph_end) step_next = step_reg + 6'd1;
            end
            OP_SEND, OP_RECV: begin
                scl = cell_low;
                if (op == OP_SEND) sdl = ~tx_byte[3'd7 - bit_reg];
                else if (phase_reg == 2'd2) shift_next = {shift_reg[6:0], sda_level};
                if (ph_end) begin
                    if (bit_reg == 3'd7) begin
                        bit_next = '0;
                        if (op == OP_RECV) begin
                            raw_next = (arg == 3'd0) ? {shift_reg, 8'h00}
                                                     : {raw_reg[15:8], shift_reg};
                        end
                        step_next = step_reg + 6'd1;
                    end else begin
                        bit_next = bit_reg + 3'd1;
                    end
                end
            end
            OP_ACK, OP_ACKR, OP_MACK: begin
                scl = cell_low;
                sdl = (op == OP_MACK);
                if (phase_reg == 2'd2 && op != OP_MACK && arg < ACK_IGNORE) begin
                    ack_next = sda_level ? (ack_reg & ~mask) : (ack_reg | mask);
                end
                if (ph_end) begin
                    if (op == OP_ACKR && ack_reg[0]) begin
                        retry_next = '0;
                        step_next  = step_reg + 6'd2;
                    end else begin
                        step_next = step_reg + 6'd1;
                    end
                end
            end
            OP_STOP, OP_RSTOP: begin
                scl = (phase_reg == 2'd0);
                sdl = (phase_reg != 2'd3);
                if (ph_end) begin
                    step_next = step_reg + 6'd1;
                    if (op == OP_RSTOP) begin
                        if (retry_reg >= cfg.retry_limit) begin
                            retry_next = '0;
                            if (cur_err_reg == ERR_NONE) cur_err_next = ERR_ADDR;
                            step_next = STEP_FSTOP;
                        end else begin
                            retry_next = retry_reg + 4'd1;
                            step_next  = step_reg - 6'd3;
                        end
                    end else if (arg == STOP_CFG) begin
                        if (ack_reg != 3'd7) begin
                            if (cur_err_reg == ERR_NONE) cur_err_next = ERR_CONFIG;
                            step_next = STEP_FSTOP;
                        end
                    end else if (arg == STOP_TRIG_T || arg == STOP_TRIG_H) begin
                        if (ack_reg[1:0] != 2'b11) begin
                            if (cur_err_reg == ERR_NONE) cur_err_next = arg;
                            step_next = STEP_FSTOP;
                        end
                    end else if (arg == STOP_KEEP_T) begin
                        pend_next = {1'b0, temp_q} - 12'd400;
                    end
                end
            end
            OP_FSTOP: begin
                scl = ~phase_reg[1];
                sdl = (phase_reg == 2'd1) || (phase_reg == 2'd2);
                if (ph_end) step_next = STEP_FINISH;
            end
            OP_FINISH: begin
                power = 1'b0; busy = 1'b0; done = 1'b1; phase_next = 2'd0;
                if (cur_err_reg == ERR_NONE) begin
                    temp_next = pend_reg;
                    hum_next  = hum_q[6:0];
                end else begin
                    sticky_next = cur_err_reg;
                end
                cur_err_next = ERR_NONE;
                step_next    = '0;
            end
            default: begin
                power = 1'b0; busy = 1'b0; phase_next = 2'd0;
                step_next = '0;
                if (start_request) begin
                    step_next = STEP_PWAIT; bit_next = '0; retry_next = '0;
                    wait_next = '0; ack_next = '0; cur_err_next = ERR_NONE;
                end
            end
        endcase
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0; phase_reg <= '0; bit_reg <= '0; shift_reg <= '0;
            raw_reg <= '0; retry_reg <= '0; wait_reg <= '0; ack_reg <= '0;
            cur_err_reg <= ERR_NONE; sticky_reg <= ERR_NONE; temp_reg <= '0;
            hum_reg <= '0; pend_reg <= '0;
        end else if (tick_en) begin
            step_reg <= step_next; phase_reg <= phase_next; bit_reg <= bit_next;
            shift_reg <= shift_next; raw_reg <= raw_next; retry_reg <= retry_next;
            wait_reg <= wait_next; ack_reg <= ack_next; cur_err_reg <= cur_err_next;
            sticky_reg <= sticky_next; temp_reg <= temp_next; hum_reg <= hum_next;
            pend_reg <= pend_next;
        end
    end

    // result of this tick
    always_comb begin
        res.scl_pull_low     = scl;
        res.sda_pull_low     = sdl;
        res.sensor_power_on  = power;
        res.busy_res         = busy;
        res.done_res         = done;
        res.temp_tenths      = temp_next;
        res.humidity_percent = hum_next;
        res.sticky_error     = sticky_next;
    end

    a_err_needs_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (cur_err_reg != ERR_NONE) |-> (op != OP_IDLE)) else $error("error held while idle");
    a_phase_zero_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        (op == OP_PWAIT || op == OP_CWAIT) |-> (phase_reg == 2'd0))
        else $error("phase moved during wait");
    a_sticky_at_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (sticky_reg != $past(sticky_reg)) |-> ($past(tick_en) && $past(op == OP_FINISH)))
        else $error("sticky code changed outside finish");

endmodule

>>> tb/tb_i2c_humidity_sensor_reader_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_i2c_humidity_sensor_reader_unit
// Self-checking bench for the bus sensor reader: a tick-level model of the
// bus sequencer predicts every result word, a small sensor stand-in answers
// acknowledge cells (with injected NACKs) and returns random data bytes, and
// the run walks through several register settings and idling patterns.
// ----------------------------------------------------------------------------
module tb_i2c_humidity_sensor_reader_unit;
    import ihsr_pkg::*;

    localparam logic [2:0] SEND_PTR_T  = 3'd4;
    localparam logic [2:0] RECV_HI     = 3'd0;
    localparam logic [2:0] RECV_LO     = 3'd1;
    localparam logic [2:0] STOP_NONE   = 3'd0;
    localparam logic [2:0] ERR_ADDR_NK = 3'd1;
    localparam int         N_STEPS     = 47;
    localparam int         N_PHASES    = 4;
    localparam int         PHASE_WORDS = 110;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = 3'd0;
    logic [19:0] cfg_data = 20'd0;

    i2c_humidity_sensor_reader_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #1 aclk = ~aclk;

    // sequencer program: operation and argument per step
    op_t seq_op [0:N_STEPS-1] = '{
        OP_IDLE, OP_PWAIT,
        OP_START, OP_SEND, OP_ACKR, OP_RSTOP, OP_SEND, OP_ACK, OP_SEND, OP_ACK,
        OP_SEND, OP_ACK, OP_STOP,
        OP_START, OP_SEND, OP_ACK, OP_SEND, OP_ACK, OP_STOP, OP_CWAIT,
        OP_START, OP_SEND, OP_ACKR, OP_RSTOP, OP_RECV, OP_MACK, OP_RECV, OP_ACK, OP_STOP,
        OP_START, OP_SEND, OP_ACK, OP_SEND, OP_ACK, OP_STOP, OP_CWAIT,
        OP_START, OP_SEND, OP_ACKR, OP_RSTOP, OP_RECV, OP_MACK, OP_RECV, OP_ACK, OP_STOP,
        OP_FINISH, OP_FSTOP
    };
    logic [2:0] seq_arg [0:N_STEPS-1] = '{
        3'd0, 3'd0,
        3'd0, SEND_ADDR_W, 3'd0, 3'd0, SEND_PTR_CFG, 3'd0, SEND_MODE, 3'd1,
        SEND_PTR_T, 3'd2, STOP_CFG,
        3'd0, SEND_ADDR_W, 3'd0, SEND_PTR_T, 3'd1, STOP_TRIG_T, 3'd0,
        3'd0, SEND_ADDR_R, 3'd0, 3'd0, RECV_HI, 3'd0, RECV_LO, ACK_IGNORE, STOP_KEEP_T,
        3'd0, SEND_ADDR_W, 3'd0, SEND_PTR_H, 3'd1, STOP_TRIG_H, 3'd0,
        3'd0, SEND_ADDR_R, 3'd0, 3'd0, RECV_HI, 3'd0, RECV_LO, ACK_IGNORE, STOP_NONE,
        3'd0, 3'd0
    };

    // model copy of the registers and sequencer state
    logic [6:0]  c_addr;
    logic [7:0]  c_mode;
    logic [3:0]  c_retry;
    logic [19:0] c_pwr, c_conv;
    logic [5:0]  st_step;
    logic [2:0]  st_phase, st_ack, st_err, st_sticky;
    logic [3:0]  st_bit, st_retry;
    logic [7:0]  st_shift;
    logic [15:0] st_raw;
    logic [19:0] st_wait;
    logic [11:0] st_temp, st_pend;
    logic [6:0]  st_hum;

    res_t expected_words [$];
    int   fail_count = 0;
    int   words_checked = 0;
    int   sequences_done = 0;
    int   error_sequences = 0;
    int   idle_pct = 0;
    int   stall_pct = 0;
    int   nack_pct = 0;

    function automatic logic [7:0] bus_byte(input logic [2:0] arg);
        case (arg)
            SEND_ADDR_W:  return {c_addr, 1'b0};
            SEND_ADDR_R:  return {c_addr, 1'b1};
            SEND_PTR_CFG: return 8'h02;
            SEND_MODE:    return c_mode;
            SEND_PTR_H:   return 8'h01;
            default:      return 8'h00;
        endcase
    endfunction

    task automatic flag_error(input logic [2:0] code);
        if (st_err == ERR_NONE) st_err = code;
        st_step = STEP_FSTOP;
    endtask

    // one bus tick of the sequencer
    task automatic step_sequencer(input logic req, input logic sda, output res_t r);
        op_t         op;
        logic [2:0]  arg, m;
        logic [1:0]  ph;
        logic        cell_low, last_ph;
        logic [19:0] lim;
        logic [5:0]  step;
        logic [7:0]  tx;
        int unsigned prod;
        step = st_step;
        op = (step < N_STEPS) ? seq_op[step] : OP_IDLE;
        arg = (step < N_STEPS) ? seq_arg[step] : 3'd0;
        ph = st_phase[1:0];
        cell_low = (ph == 2'd0 || ph == 2'd3);
        last_ph = (ph == 2'd3);
        r = '0;
        r.sensor_power_on = 1'b1;
        r.busy_res = 1'b1;
        st_phase = last_ph ? 3'd0 : {1'b0, ph} + 3'd1;
        case (op)
            OP_PWAIT, OP_CWAIT: begin
                lim = (op == OP_PWAIT) ? c_pwr : c_conv;
                st_phase = 3'd0;
                if ({1'b0, st_wait} + 21'd1 >= {1'b0, lim}) begin
                    st_wait = '0;
                    st_step = step + 6'd1;
                end else begin
                    st_wait = st_wait + 20'd1;
                end
            end
            OP_START: begin
                if (ph == 2'd0) st_ack = '0;
                r.scl_pull_low = (ph == 2'd3);
                r.sda_pull_low = (ph >= 2'd2);
                if (last_ph) st_step = step + 6'd1;
            end
            OP_SEND, OP_RECV: begin
                r.scl_pull_low = cell_low;
                if (op == OP_SEND) begin
                    tx = bus_byte(arg);
                    r.sda_pull_low = ~tx[3'd7 - st_bit[2:0]];
                end else if (ph == 2'd2) begin
                    st_shift = {st_shift[6:0], sda};
                end
                if (last_ph) begin
                    if (st_bit[2:0] == 3'd7) begin
                        st_bit = '0;
                        if (op == OP_RECV)
                            st_raw = (arg == RECV_HI) ? {st_shift, 8'h00}
                                                      : {st_raw[15:8], st_shift};
                        st_step = step + 6'd1;
                    end else begin
                        st_bit = {1'b0, st_bit[2:0] + 3'd1};
                    end
                end
            end
            OP_ACK, OP_ACKR, OP_MACK: begin
                r.scl_pull_low = cell_low;
                r.sda_pull_low = (op == OP_MACK);
                if (ph == 2'd2 && op != OP_MACK && arg < ACK_IGNORE) begin
                    m = 3'd1 << arg;
                    st_ack = sda ? (st_ack & ~m) : (st_ack | m);
                end
                if (last_ph) begin
                    if (op == OP_ACKR && st_ack[0]) begin
                        st_retry = '0;
                        st_step = step + 6'd2;
                    end else begin
                        st_step = step + 6'd1;
                    end
                end
            end
            OP_STOP, OP_RSTOP: begin
                r.scl_pull_low = (ph == 2'd0);
                r.sda_pull_low = (ph != 2'd3);
                if (last_ph) begin
                    st_step = step + 6'd1;
                    if (op == OP_RSTOP) begin
                        if (st_retry >= c_retry) begin
                            st_retry = '0;
                            flag_error(ERR_ADDR_NK);
                        end else begin
                            st_retry = st_retry + 4'd1;
                            st_step = step - 6'd3;
                        end
                    end else if (arg == STOP_CFG) begin
                        if (st_ack != 3'b111) flag_error(ERR_CONFIG);
                    end else if (arg == STOP_TRIG_T || arg == STOP_TRIG_H) begin
                        if (st_ack[1:0] != 2'b11) flag_error(arg);
                    end else if (arg == STOP_KEEP_T) begin
                        prod = st_raw * 1650 / 65535 + 4096 - 400;
                        st_pend = prod[11:0];
                    end
                end
            end
            OP_FSTOP: begin
                r.scl_pull_low = (ph <= 2'd1);
                r.sda_pull_low = (ph >= 2'd1 && ph <= 2'd2);
                if (last_ph) st_step = STEP_FINISH;
            end
            OP_FINISH: begin
                r.sensor_power_on = 1'b0;
                r.busy_res = 1'b0;
                r.done_res = 1'b1;
                st_phase = '0;
                if (st_err == ERR_NONE) begin
                    prod = st_raw * 100 / 65535;
                    st_temp = st_pend;
                    st_hum = prod[6:0];
                end else begin
                    st_sticky = st_err;
                    error_sequences++;
                end
                sequences_done++;
                st_err = ERR_NONE;
                st_step = '0;
            end
            default: begin
                // idle, also any step outside the program
                r.sensor_power_on = 1'b0;
                r.busy_res = 1'b0;
                st_phase = '0;
                st_step = '0;
                if (req) begin
                    st_step = STEP_PWAIT;
                    st_bit = '0;
                    st_retry = '0;
                    st_wait = '0;
                    st_ack = '0;
                    st_err = ERR_NONE;
                end
            end
        endcase
        r.temp_tenths = st_temp;
        r.humidity_percent = st_hum;
        r.sticky_error = st_sticky;
    endtask

    // drive one tick word, wait for acceptance, then predict its result
    task automatic send_tick(input logic req, input logic sda, input bit typed,
                             input res_t typed_word);
        res_t r;
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'd0, sda, req};
        do @(posedge aclk); while (!s_tready);
        step_sequencer(req, sda, r);
        expected_words.push_back(typed ? typed_word : r);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [19:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_DEV_ADDR:   c_addr = val[6:0];
            CFG_MODE:       c_mode = val[7:0];
            CFG_RETRY:      c_retry = val[3:0];
            CFG_PWR_TICKS:  c_pwr = val;
            default:        c_conv = val;
        endcase
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // receiver stalls
    always @(posedge aclk) m_tready <= ($urandom_range(99) >= stall_pct);

    task automatic report_field(input string name, input int exp_v, input int got_v);
        $display("%0t mismatch %s expected %0d actual %0d", $time, name, exp_v, got_v);
        fail_count++;
    endtask

    // result checker
    always @(posedge aclk) begin
        res_t e, g;
        if (aresetn && m_tvalid && m_tready) begin
            g.scl_pull_low = m_tdata[0];
            g.sda_pull_low = m_tdata[1];
            g.sensor_power_on = m_tdata[2];
            g.busy_res = m_tdata[3];
            g.done_res = m_tdata[4];
            g.temp_tenths = m_tdata[16:5];
            g.humidity_percent = m_tdata[23:17];
            g.sticky_error = m_tdata[26:24];
            if (expected_words.size() == 0) begin
                $display("%0t unexpected result word %h", $time, m_tdata);
                fail_count++;
            end else begin
                e = expected_words.pop_front();
                words_checked++;
                if (g.scl_pull_low !== e.scl_pull_low)
                    report_field("scl_pull_low", e.scl_pull_low, g.scl_pull_low);
                if (g.sda_pull_low !== e.sda_pull_low)
                    report_field("sda_pull_low", e.sda_pull_low, g.sda_pull_low);
                if (g.sensor_power_on !== e.sensor_power_on)
                    report_field("sensor_power_on", e.sensor_power_on, g.sensor_power_on);
                if (g.busy_res !== e.busy_res)
                    report_field("busy_res", e.busy_res, g.busy_res);
                if (g.done_res !== e.done_res)
                    report_field("done_res", e.done_res, g.done_res);
                if (g.temp_tenths !== e.temp_tenths)
                    report_field("temp_tenths", e.temp_tenths, g.temp_tenths);
                if (g.humidity_percent !== e.humidity_percent)
                    report_field("humidity_percent", e.humidity_percent, g.humidity_percent);
                if (g.sticky_error !== e.sticky_error)
                    report_field("sticky_error", e.sticky_error, g.sticky_error);
            end
        end
    end

    typedef struct {
        logic req;
        logic sda;
        bit   typed;
        res_t word;
    } tick_row_t;

    tick_row_t directed [$];

    // timeout
    initial begin
        #4000000;
        $display("[i2c_humidity_sensor_reader_unit] ERROR");
        $finish;
    end

    initial begin
        res_t zero_word, wait_word;
        int   counted;
        logic req, sda;
        op_t  cur_op;
        c_addr = 7'd64; c_mode = 8'd0; c_retry = 4'd3; c_pwr = 20'd60000; c_conv = 20'd28000;
        st_step = '0; st_phase = '0; st_bit = '0; st_shift = '0; st_raw = '0;
        st_retry = '0; st_wait = '0; st_ack = '0; st_err = '0; st_sticky = '0;
        st_temp = '0; st_hum = '0; st_pend = '0;
        zero_word = '0;
        wait_word = '0;
        wait_word.sensor_power_on = 1'b1;
        wait_word.busy_res = 1'b1;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // idle words straight after reset carry the reset values
        directed.push_back('{1'b0, 1'b0, 1'b1, zero_word});
        directed.push_back('{1'b0, 1'b1, 1'b1, zero_word});
        foreach (directed[i]) send_tick(directed[i].req, directed[i].sda, 1'b1, directed[i].word);
        drain_results();
        directed.delete();

        for (int p = 0; p < N_PHASES; p++) begin
            // registers are only touched while the sequencer sits idle
            idle_pct = 0;
            stall_pct = 0;
            write_reg(CFG_DEV_ADDR, (p == 0) ? 20'd0 : (p == 1) ? 20'd127 : $urandom_range(127));
            write_reg(CFG_MODE, (p == 0) ? 20'd0 : (p == 1) ? 20'd255 : $urandom_range(255));
            write_reg(CFG_RETRY, (p == 0) ? 20'd0 : (p == 1) ? 20'd15 : $urandom_range(4));
            write_reg(CFG_PWR_TICKS, (p == 0) ? 20'd0 : (p == 1) ? 20'd1 : $urandom_range(6));
            write_reg(CFG_CONV_TICKS, (p == 0) ? 20'd1 : (p == 1) ? 20'd0 : $urandom_range(6));
            cfg_valid <= 1'b0;
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 88; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 88; end
                default: begin idle_pct = 16; stall_pct = 16; end
            endcase
            nack_pct = (p == 1) ? 30 : (p % 3 == 0) ? 0 : (p % 3 == 1) ? 2 : 8;

            // directed start: request, power wait, the start cells and the first address bits
            if (p == 0) begin
                directed.push_back('{1'b1, 1'b0, 1'b1, zero_word});
                directed.push_back('{1'b0, 1'b1, 1'b1, wait_word});
                for (int k = 0; k < 18; k++)
                    directed.push_back('{k[0], k[1], 1'b0, zero_word});
                foreach (directed[i])
                    send_tick(directed[i].req, directed[i].sda, directed[i].typed,
                              directed[i].word);
            end

            // random ticks; the sensor stand-in acknowledges most cells
            counted = 0;
            while (counted < PHASE_WORDS || st_step != 6'd0) begin
                cur_op = (st_step < N_STEPS) ? seq_op[st_step] : OP_IDLE;
                req = ($urandom_range(2) == 0);
                if (cur_op == OP_ACK || cur_op == OP_ACKR)
                    sda = ($urandom_range(99) < nack_pct);
                else
                    sda = $urandom_range(1);
                if (cur_op != OP_IDLE || req) counted++;
                send_tick(req, sda, 1'b0, zero_word);
            end
            drain_results();
        end

        idle_pct = 0;
        stall_pct = 0;
        drain_results();
        $display("checked %0d result words over %0d sequences, %0d of them ending in error",
                 words_checked, sequences_done, error_sequences);
        if (fail_count == 0) begin
            $display("[i2c_humidity_sensor_reader_unit] OK");
        end else begin
            $display("[i2c_humidity_sensor_reader_unit] ERROR");
        end
        $finish;
    end

endmodule
